@@ rtl/eeg_pp_pkg.sv @@
// Shared types, codes and helpers for the EEG headset packet parser.
package eeg_pp_pkg;

    localparam int BYTE_W    = 8;
    localparam int NUM_SLOTS = 13;
    localparam int SLOT_W    = 4;
    localparam int STAGE_W   = 24;
    localparam int VALUE_W   = 25;
    localparam int EEG_BANDS = 8;
    localparam int TDATA_W   = 32;

    localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'hAA;
    localparam logic [BYTE_W-1:0] CODE_POOR   = 8'h02;
    localparam logic [BYTE_W-1:0] CODE_ATTN   = 8'h04;
    localparam logic [BYTE_W-1:0] CODE_MED    = 8'h05;
    localparam logic [BYTE_W-1:0] CODE_BLINK  = 8'h16;
    localparam logic [BYTE_W-1:0] CODE_RAW    = 8'h80;
    localparam logic [BYTE_W-1:0] CODE_EEG    = 8'h83;

    localparam logic [SLOT_W-1:0] SLOT_POOR  = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_ATTN  = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_MED   = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_BLINK = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_RAW   = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_EEG   = 4'd5;

    localparam logic STATUS_VALUE = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK,
        PH_EMIT
    } phase_t;

    typedef enum logic [3:0] {
        FK_CODE,
        FK_POOR,
        FK_ATTN,
        FK_MED,
        FK_BLINK,
        FK_RAWLEN,
        FK_RAW,
        FK_EEGLEN,
        FK_EEG
    } field_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start_pkt;
        logic payload_byte;
        logic load_error;
        logic emit_slot;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_sync;
        logic byte_zero;
        logic last_payload;
        logic sum_ok;
        logic pend_any;
        logic pend_last;
        logic out_free;
    } sts_t;

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [SLOT_W-1:0] lowest_set(input logic [NUM_SLOTS-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/eeg_pp_ctrl.sv @@
// Frame controller: sync hunt, length, payload, checksum and result drain.
module eeg_pp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  eeg_pp_pkg::sts_t  sts,
    output eeg_pp_pkg::cmd_t  cmd
);

    eeg_pp_pkg::phase_t state_reg, state_next;
    logic accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= eeg_pp_pkg::PH_SYNC1;
        end else begin
            state_reg <= state_next;
        end
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b1;
        cmd        = '0;
        case (state_reg)
            eeg_pp_pkg::PH_SYNC1: begin
                if (accept && sts.is_sync) begin
                    state_next = eeg_pp_pkg::PH_SYNC2;
                end
            end
            eeg_pp_pkg::PH_SYNC2: begin
                if (accept) begin
                    state_next = sts.is_sync ? eeg_pp_pkg::PH_LEN : eeg_pp_pkg::PH_SYNC1;
                end
            end
            eeg_pp_pkg::PH_LEN: begin
                if (accept) begin
                    cmd.start_pkt = 1'b1;
                    state_next = sts.byte_zero ? eeg_pp_pkg::PH_CHECK
                                               : eeg_pp_pkg::PH_PAYLOAD;
                end
            end
            eeg_pp_pkg::PH_PAYLOAD: begin
                if (accept) begin
                    cmd.payload_byte = 1'b1;
                    if (sts.last_payload) begin
                        state_next = eeg_pp_pkg::PH_CHECK;
                    end
                end
            end
            eeg_pp_pkg::PH_CHECK: begin
                // hold the checksum byte until the error result can be loaded
                s_tready = sts.out_free;
                if (accept) begin
                    if (sts.sum_ok) begin
                        state_next = eeg_pp_pkg::PH_EMIT;
                    end else begin
                        cmd.load_error = 1'b1;
                        state_next = eeg_pp_pkg::PH_SYNC1;
                    end
                end
            end
            eeg_pp_pkg::PH_EMIT: begin
                s_tready = 1'b0;
                if (!sts.pend_any) begin
                    state_next = eeg_pp_pkg::PH_SYNC1;
                end else if (sts.out_free) begin
                    cmd.emit_slot = 1'b1;
                    if (sts.pend_last) begin
                        state_next = eeg_pp_pkg::PH_SYNC1;
                    end
                end
            end
            default: begin
                state_next = eeg_pp_pkg::PH_SYNC1;
            end
        endcase
    end

endmodule

@@ rtl/eeg_pp_dpath.sv @@
// Datapath: byte counter, checksum, field decoder, staged values, output register.
module eeg_pp_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [eeg_pp_pkg::BYTE_W-1:0]       rx_byte,
    input  eeg_pp_pkg::cmd_t                    cmd,
    output eeg_pp_pkg::sts_t                    sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [eeg_pp_pkg::TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    localparam int NS = eeg_pp_pkg::NUM_SLOTS;
    localparam int SW = eeg_pp_pkg::SLOT_W;

    logic [7:0]                        bytes_left_reg, bytes_left_next;
    logic [7:0]                        sum_reg, sum_next;
    eeg_pp_pkg::field_kind_t           fk_reg, fk_next;
    logic [1:0]                        sub_reg, sub_next;
    logic [2:0]                        band_reg, band_next;
    logic [eeg_pp_pkg::STAGE_W-1:0]    acc_reg, acc_next;
    logic [NS-1:0]                     valid_reg, valid_next;
    logic [eeg_pp_pkg::STAGE_W-1:0]    store [NS];

    logic                              stage_we;
    logic [SW-1:0]                     stage_slot;
    logic [eeg_pp_pkg::STAGE_W-1:0]    stage_val;

    logic [SW-1:0]                     emit_idx;
    logic [NS-1:0]                     emit_bit;
    logic [eeg_pp_pkg::STAGE_W-1:0]    emit_raw;
    logic [eeg_pp_pkg::VALUE_W-1:0]    emit_val;

    logic                              out_valid_reg;
    logic [SW-1:0]                     out_code_reg;
    logic [eeg_pp_pkg::VALUE_W-1:0]    out_value_reg;
    logic                              out_status_reg;
    logic                              out_last_reg;

    assign emit_idx = eeg_pp_pkg::lowest_set(valid_reg);
    assign emit_bit = NS'(1) << emit_idx;
    assign emit_raw = store[emit_idx];
    assign emit_val = (emit_idx == eeg_pp_pkg::SLOT_RAW)
                    ? {{(eeg_pp_pkg::VALUE_W-16){emit_raw[15]}}, emit_raw[15:0]}
                    : {1'b0, emit_raw};

    assign sts.is_sync      = (rx_byte == eeg_pp_pkg::SYNC_BYTE);
    assign sts.byte_zero    = (rx_byte == '0);
    assign sts.last_payload = (bytes_left_reg == 8'd1);
    assign sts.sum_ok       = (rx_byte == ~sum_reg);
    assign sts.pend_any     = |valid_reg;
    assign sts.pend_last    = ((valid_reg & ~emit_bit) == '0);
    assign sts.out_free     = !out_valid_reg || m_tready;

    // Payload decode
    always_comb begin
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;
        fk_next         = fk_reg;
        sub_next        = sub_reg;
        band_next       = band_reg;
        acc_next        = acc_reg;
        valid_next      = valid_reg;
        stage_we        = 1'b0;
        stage_slot      = eeg_pp_pkg::SLOT_POOR;
        stage_val       = {16'd0, rx_byte};

        if (cmd.start_pkt) begin
            bytes_left_next = rx_byte;
            sum_next        = '0;
            fk_next         = eeg_pp_pkg::FK_CODE;
            sub_next        = '0;
            band_next       = '0;
            acc_next        = '0;
            valid_next      = '0;
        end else if (cmd.payload_byte) begin
            bytes_left_next = bytes_left_reg - 8'd1;
            sum_next        = sum_reg + rx_byte;
            case (fk_reg)
                eeg_pp_pkg::FK_CODE: begin
                    case (rx_byte)
                        eeg_pp_pkg::CODE_POOR:  fk_next = eeg_pp_pkg::FK_POOR;
                        eeg_pp_pkg::CODE_ATTN:  fk_next = eeg_pp_pkg::FK_ATTN;
                        eeg_pp_pkg::CODE_MED:   fk_next = eeg_pp_pkg::FK_MED;
                        eeg_pp_pkg::CODE_BLINK: fk_next = eeg_pp_pkg::FK_BLINK;
                        eeg_pp_pkg::CODE_RAW:   fk_next = eeg_pp_pkg::FK_RAWLEN;
                        eeg_pp_pkg::CODE_EEG:   fk_next = eeg_pp_pkg::FK_EEGLEN;
                        default:                fk_next = eeg_pp_pkg::FK_CODE;
                    endcase
                end
                eeg_pp_pkg::FK_POOR: begin
                    stage_we   = 1'b1;
                    stage_slot = eeg_pp_pkg::SLOT_POOR;
                    fk_next    = eeg_pp_pkg::FK_CODE;
                end
                eeg_pp_pkg::FK_ATTN: begin
                    stage_we   = 1'b1;
                    stage_slot = eeg_pp_pkg::SLOT_ATTN;
                    fk_next    = eeg_pp_pkg::FK_CODE;
                end
                eeg_pp_pkg::FK_MED: begin
                    stage_we   = 1'b1;
                    stage_slot = eeg_pp_pkg::SLOT_MED;
                    fk_next    = eeg_pp_pkg::FK_CODE;
                end
                eeg_pp_pkg::FK_BLINK: begin
                    stage_we   = 1'b1;
                    stage_slot = eeg_pp_pkg::SLOT_BLINK;
                    fk_next    = eeg_pp_pkg::FK_CODE;
                end
                eeg_pp_pkg::FK_RAWLEN: begin
                    // skip the row length byte
                    fk_next  = eeg_pp_pkg::FK_RAW;
                    sub_next = '0;
                    acc_next = '0;
                end
                eeg_pp_pkg::FK_RAW: begin
                    acc_next = {8'd0, acc_reg[7:0], rx_byte};
                    if (sub_reg != 2'd0) begin
                        stage_we   = 1'b1;
                        stage_slot = eeg_pp_pkg::SLOT_RAW;
                        stage_val  = {8'd0, acc_reg[7:0], rx_byte};
                        fk_next    = eeg_pp_pkg::FK_CODE;
                        sub_next   = '0;
                    end else begin
                        sub_next = 2'd1;
                    end
                end
                eeg_pp_pkg::FK_EEGLEN: begin
                    fk_next   = eeg_pp_pkg::FK_EEG;
                    sub_next  = '0;
                    band_next = '0;
                    acc_next  = '0;
                end
                eeg_pp_pkg::FK_EEG: begin
                    acc_next = {acc_reg[15:0], rx_byte};
                    if (sub_reg == 2'd2) begin
                        // third byte closes a band
                        stage_we   = 1'b1;
                        stage_slot = eeg_pp_pkg::SLOT_EEG + SW'(band_reg);
                        stage_val  = {acc_reg[15:0], rx_byte};
                        acc_next   = '0;
                        sub_next   = '0;
                        band_next  = band_reg + 3'd1;
                        if (band_reg == 3'(eeg_pp_pkg::EEG_BANDS - 1)) begin
                            fk_next = eeg_pp_pkg::FK_CODE;
                        end
                    end else begin
                        sub_next = sub_reg + 2'd1;
                    end
                end
                default: begin
                    fk_next = eeg_pp_pkg::FK_CODE;
                end
            endcase
            if (stage_we) begin
                valid_next = valid_reg | (NS'(1) << stage_slot);
            end
        end else if (cmd.emit_slot) begin
            valid_next = valid_reg & ~emit_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            sum_reg        <= '0;
            fk_reg         <= eeg_pp_pkg::FK_CODE;
            sub_reg        <= '0;
            band_reg       <= '0;
            acc_reg        <= '0;
            valid_reg      <= '0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            sum_reg        <= sum_next;
            fk_reg         <= fk_next;
            sub_reg        <= sub_next;
            band_reg       <= band_next;
            acc_reg        <= acc_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_we) begin
            store[stage_slot] <= stage_val;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_error || cmd.emit_slot) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_error) begin
            out_status_reg <= eeg_pp_pkg::STATUS_ERROR;
            out_code_reg   <= '0;
            out_value_reg  <= '0;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit_slot) begin
            out_status_reg <= eeg_pp_pkg::STATUS_VALUE;
            out_code_reg   <= emit_idx;
            out_value_reg  <= emit_val;
            out_last_reg   <= sts.pend_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(eeg_pp_pkg::TDATA_W - SW - eeg_pp_pkg::VALUE_W){1'b0}},
                       out_value_reg, out_code_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/eeg_headset_packet_parser_core.sv @@
// Top level of the EEG headset packet parser.
// The parser takes one serial byte per transfer on the s_ channel and walks the
// packet framing: two 0xAA sync bytes, a length byte, that many payload bytes and
// a checksum byte. Each byte is absorbed in the cycle it is accepted, so the input
// side runs at one byte per cycle for sync, length and payload bytes. Payload rows
// (poor signal, attention, meditation, blink, raw and the eight EEG bands) are
// decoded on the fly into thirteen staged slots; a later row overwrites an earlier
// one, and rows cut short by the end of the payload are dropped, except EEG bands
// already complete. When the checksum byte matches the ones complement of the
// payload sum, every staged slot is sent on the m_ channel in ascending code
// order, one transfer per cycle while m_tready allows, with m_tlast on the final
// one; a packet with nothing staged sends nothing. On a mismatch a single transfer
// with m_tuser set, zero data and m_tlast set is sent. The checksum byte is held
// while an earlier result still waits on m_tready. After a good checksum the drain
// holds s_tready low, also when nothing is staged, until each staged slot is loaded
// into the output register, stretched by any backpressure on m_tready; the output
// register lets the next packet's first sync bytes in while the last result waits.
module eeg_headset_packet_parser_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [eeg_pp_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [eeg_pp_pkg::TDATA_W-1:0]     m_tdata,   // [3:0] field_code, [28:4] field_value
    output logic                               m_tuser,   // [0] status
    output logic                               m_tlast    // last_of_packet
);

    eeg_pp_pkg::cmd_t cmd;
    eeg_pp_pkg::sts_t sts;

    // Framing and drain sequencing
    eeg_pp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Checksum, row decode, staged slots and the result register
    eeg_pp_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rx_byte  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/eeg_pp_checker.sv @@
// Port-level checks for the EEG headset packet parser, bound to the top level.
module eeg_pp_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [eeg_pp_pkg::TDATA_W-1:0]     m_tdata,
    input logic                               m_tuser,
    input logic                               m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("checksum error result malformed");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[3:0] <= 4'd12)
        else $error("field code out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a fresh error result follows the transfer of its checksum byte
    a_err_after_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && (!$past(m_tvalid) || $past(m_tready))
        |-> $past(s_tvalid && s_tready))
        else $error("error result without a checksum byte");

endmodule

bind eeg_headset_packet_parser_core eeg_pp_checker u_eeg_pp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/eeg_headset_packet_parser_core_test.sv @@
// Self-checking testbench for the EEG headset packet parser core.
`timescale 1ns / 100ps

module eeg_headset_packet_parser_core_test;

    // One result transfer as seen on the m_ channel.
    typedef struct packed {
        logic                          status;
        logic [eeg_pp_pkg::SLOT_W-1:0]  code;
        logic [eeg_pp_pkg::VALUE_W-1:0] value;
        logic                          last;
    } field_report_t;

    // Directed stimulus row: a byte, and where obvious, the one report it closes with.
    typedef struct packed {
        logic [eeg_pp_pkg::BYTE_W-1:0] rx;
        logic                          typed;
        field_report_t                 want;
    } script_row_t;

    localparam field_report_t NO_REPORT    = '0;
    localparam field_report_t CHECKSUM_ERR = '{eeg_pp_pkg::STATUS_ERROR,
                                               eeg_pp_pkg::SLOT_POOR, 25'd0, 1'b1};
    localparam field_report_t RAW_MOST_NEG = '{eeg_pp_pkg::STATUS_VALUE,
                                               eeg_pp_pkg::SLOT_RAW, 25'h1FF8000, 1'b1};

    localparam int SCRIPT_LEN   = 27;
    localparam int RANDOM_ITEMS = 470;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // stray byte, then a pair whose second byte is not sync
        '{8'h55, 1'b0, NO_REPORT},
        '{eeg_pp_pkg::SYNC_BYTE, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        // empty payload with a bad checksum
        '{eeg_pp_pkg::SYNC_BYTE, 1'b0, NO_REPORT},
        '{eeg_pp_pkg::SYNC_BYTE, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b1, CHECKSUM_ERR},
        // most negative raw, then an EEG row cut off by the payload end
        '{eeg_pp_pkg::SYNC_BYTE, 1'b0, NO_REPORT},
        '{eeg_pp_pkg::SYNC_BYTE, 1'b0, NO_REPORT},
        '{8'h05, 1'b0, NO_REPORT},
        '{eeg_pp_pkg::CODE_RAW, 1'b0, NO_REPORT},
        '{8'h02, 1'b0, NO_REPORT},
        '{8'h80, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{eeg_pp_pkg::CODE_EEG, 1'b0, NO_REPORT},
        '{8'h7A, 1'b1, RAW_MOST_NEG},
        // attention, blink, unknown code, meditation; three reports
        '{eeg_pp_pkg::SYNC_BYTE, 1'b0, NO_REPORT},
        '{eeg_pp_pkg::SYNC_BYTE, 1'b0, NO_REPORT},
        '{8'h07, 1'b0, NO_REPORT},
        '{eeg_pp_pkg::CODE_ATTN, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{eeg_pp_pkg::CODE_BLINK, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, NO_REPORT},
        '{8'h99, 1'b0, NO_REPORT},
        '{eeg_pp_pkg::CODE_MED, 1'b0, NO_REPORT},
        '{8'h02, 1'b0, NO_REPORT},
        '{8'h46, 1'b0, NO_REPORT}
    };

    localparam logic [eeg_pp_pkg::BYTE_W-1:0] SINGLE_CODES [4] = '{
        eeg_pp_pkg::CODE_POOR, eeg_pp_pkg::CODE_ATTN,
        eeg_pp_pkg::CODE_MED, eeg_pp_pkg::CODE_BLINK
    };

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [eeg_pp_pkg::BYTE_W-1:0]      s_tdata  = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [eeg_pp_pkg::TDATA_W-1:0]     m_tdata;
    logic                               m_tuser;
    logic                               m_tlast;

    // Predictor state
    eeg_pp_pkg::phase_t                 parse_phase;
    eeg_pp_pkg::field_kind_t            row_kind;
    logic [7:0]                         payload_left;
    logic [7:0]                         payload_sum;
    logic [4:0]                         row_pos;
    logic [eeg_pp_pkg::STAGE_W-1:0]     row_acc;
    logic [eeg_pp_pkg::STAGE_W-1:0]     staged_val [eeg_pp_pkg::NUM_SLOTS];
    logic [eeg_pp_pkg::NUM_SLOTS-1:0]   staged_mask;

    field_report_t          pending_reports [$];
    field_report_t          oldest_report;
    int                     failures   = 0;
    int                     items_sent = 0;
    bit                     src_fast   = 1'b0;
    int                     sink_stall = 0;
    int                     sink_pick;
    logic [15:0]            sink_cycle = '0;

    eeg_headset_packet_parser_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic stage_field(input int slot, input logic [eeg_pp_pkg::STAGE_W-1:0] v);
        staged_val[slot]  = v;
        staged_mask[slot] = 1'b1;
    endtask

    // Advance the predicted parser by one byte; queue the reports it closes a packet with.
    task automatic predict_reports(input logic [eeg_pp_pkg::BYTE_W-1:0] b);
        logic [7:0]                     want_sum;
        logic [eeg_pp_pkg::VALUE_W-1:0] v;
        field_report_t                  r;
        int                             n;
        n = 0;
        case (parse_phase)
            eeg_pp_pkg::PH_SYNC1: begin
                parse_phase = (b == eeg_pp_pkg::SYNC_BYTE) ? eeg_pp_pkg::PH_SYNC2
                                                           : eeg_pp_pkg::PH_SYNC1;
            end
            eeg_pp_pkg::PH_SYNC2: begin
                parse_phase = (b == eeg_pp_pkg::SYNC_BYTE) ? eeg_pp_pkg::PH_LEN
                                                           : eeg_pp_pkg::PH_SYNC1;
            end
            eeg_pp_pkg::PH_LEN: begin
                payload_left = b;
                payload_sum  = '0;
                staged_mask  = '0;
                row_kind     = eeg_pp_pkg::FK_CODE;
                row_pos      = '0;
                row_acc      = '0;
                parse_phase  = (b == 8'd0) ? eeg_pp_pkg::PH_CHECK : eeg_pp_pkg::PH_PAYLOAD;
            end
            eeg_pp_pkg::PH_PAYLOAD: begin
                payload_sum = payload_sum + b;
                case (row_kind)
                    eeg_pp_pkg::FK_CODE: begin
                        case (b)
                            eeg_pp_pkg::CODE_POOR:  row_kind = eeg_pp_pkg::FK_POOR;
                            eeg_pp_pkg::CODE_ATTN:  row_kind = eeg_pp_pkg::FK_ATTN;
                            eeg_pp_pkg::CODE_MED:   row_kind = eeg_pp_pkg::FK_MED;
                            eeg_pp_pkg::CODE_BLINK: row_kind = eeg_pp_pkg::FK_BLINK;
                            eeg_pp_pkg::CODE_RAW:   row_kind = eeg_pp_pkg::FK_RAWLEN;
                            eeg_pp_pkg::CODE_EEG:   row_kind = eeg_pp_pkg::FK_EEGLEN;
                            default:                row_kind = eeg_pp_pkg::FK_CODE;
                        endcase
                    end
                    eeg_pp_pkg::FK_POOR, eeg_pp_pkg::FK_ATTN,
                    eeg_pp_pkg::FK_MED, eeg_pp_pkg::FK_BLINK: begin
                        stage_field(int'(row_kind) - int'(eeg_pp_pkg::FK_POOR),
                                    {16'h0000, b});
                        row_kind = eeg_pp_pkg::FK_CODE;
                    end
                    eeg_pp_pkg::FK_RAWLEN: begin
                        row_kind = eeg_pp_pkg::FK_RAW;
                        row_pos  = '0;
                        row_acc  = '0;
                    end
                    eeg_pp_pkg::FK_RAW: begin
                        row_acc = {8'h00, row_acc[7:0], b};
                        if (row_pos >= 5'd1) begin
                            stage_field(int'(eeg_pp_pkg::SLOT_RAW), row_acc);
                            row_kind = eeg_pp_pkg::FK_CODE;
                            row_pos  = '0;
                        end else begin
                            row_pos = 5'd1;
                        end
                    end
                    eeg_pp_pkg::FK_EEGLEN: begin
                        row_kind = eeg_pp_pkg::FK_EEG;
                        row_pos  = '0;
                        row_acc  = '0;
                    end
                    eeg_pp_pkg::FK_EEG: begin
                        row_acc = {row_acc[15:0], b};
                        // a band is complete on its third byte
                        if (row_pos % 3 == 2) begin
                            stage_field(int'(eeg_pp_pkg::SLOT_EEG) + row_pos / 3, row_acc);
                            row_acc = '0;
                        end
                        row_pos = row_pos + 5'd1;
                        if (row_pos >= 5'd24) begin
                            row_kind = eeg_pp_pkg::FK_CODE;
                            row_pos  = '0;
                        end
                    end
                    default: row_kind = eeg_pp_pkg::FK_CODE;
                endcase
                payload_left = payload_left - 8'd1;
                if (payload_left == 8'd0) begin
                    parse_phase = eeg_pp_pkg::PH_CHECK;
                end
            end
            eeg_pp_pkg::PH_CHECK: begin
                want_sum = ~payload_sum;
                if (want_sum == b) begin
                    for (int s = 0; s < eeg_pp_pkg::NUM_SLOTS; s++) begin
                        if (staged_mask[s]) begin
                            v = {1'b0, staged_val[s]};
                            // raw is the only signed field
                            if (s == int'(eeg_pp_pkg::SLOT_RAW) && staged_val[s][15]) begin
                                v = {9'h1FF, staged_val[s][15:0]};
                            end
                            r.status = eeg_pp_pkg::STATUS_VALUE;
                            r.code   = eeg_pp_pkg::SLOT_W'(s);
                            r.value  = v;
                            r.last   = 1'b0;
                            pending_reports.push_back(r);
                            n++;
                        end
                    end
                    if (n > 0) begin
                        r      = pending_reports.pop_back();
                        r.last = 1'b1;
                        pending_reports.push_back(r);
                    end
                end else begin
                    pending_reports.push_back(CHECKSUM_ERR);
                end
                parse_phase = eeg_pp_pkg::PH_SYNC1;
            end
            default: parse_phase = eeg_pp_pkg::PH_SYNC1;
        endcase
    endtask

    // Offer one byte after a random gap and hold it until the transfer.
    task automatic send_byte(input logic [eeg_pp_pkg::BYTE_W-1:0] rx, input logic typed,
                             input field_report_t want);
        int gap;
        int pick;
        int queued;
        pick = $urandom_range(0, 99);
        if (src_fast || pick < 60) begin
            gap = 0;
        end else if (pick < 95) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        queued = pending_reports.size();
        predict_reports(rx);
        // typed rows carry their own expectation in place of the predicted one
        if (typed) begin
            while (pending_reports.size() > queued) void'(pending_reports.pop_back());
            pending_reports.push_back(want);
        end
        items_sent++;
    endtask

    function automatic logic [eeg_pp_pkg::BYTE_W-1:0] field_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Build a packet from random rows, cut to its length, with a mostly good checksum.
    task automatic send_random_packet(input bit longest);
        logic [eeg_pp_pkg::BYTE_W-1:0] body [$];
        logic [eeg_pp_pkg::BYTE_W-1:0] stray;
        logic [7:0]                    sum;
        logic [7:0]                    chk;
        int                            want_len;
        int                            pick;
        src_fast = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 3)) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, NO_REPORT);
            end
        end else if (pick < 20) begin
            stray = 8'($urandom_range(0, 255));
            if (stray == eeg_pp_pkg::SYNC_BYTE) begin
                stray = ~stray;
            end
            send_byte(eeg_pp_pkg::SYNC_BYTE, 1'b0, NO_REPORT);
            send_byte(stray, 1'b0, NO_REPORT);
        end
        pick = $urandom_range(0, 99);
        if (longest) begin
            want_len = 255;
        end else if (pick < 6) begin
            want_len = 0;
        end else if (pick < 75) begin
            want_len = $urandom_range(1, 16);
        end else begin
            want_len = $urandom_range(26, 48);
        end
        while (body.size() < want_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                body.push_back(SINGLE_CODES[$urandom_range(0, 3)]);
                body.push_back(field_byte());
            end else if (pick < 75) begin
                body.push_back(eeg_pp_pkg::CODE_RAW);
                repeat (3) body.push_back(field_byte());
            end else if (pick < 87) begin
                body.push_back(eeg_pp_pkg::CODE_EEG);
                repeat (25) body.push_back(field_byte());
            end else begin
                body.push_back(8'($urandom_range(0, 255)));
            end
        end
        while (body.size() > want_len) void'(body.pop_back());
        send_byte(eeg_pp_pkg::SYNC_BYTE, 1'b0, NO_REPORT);
        send_byte(eeg_pp_pkg::SYNC_BYTE, 1'b0, NO_REPORT);
        send_byte(8'(want_len), 1'b0, NO_REPORT);
        sum = '0;
        foreach (body[i]) begin
            sum = sum + body[i];
            send_byte(body[i], 1'b0, NO_REPORT);
        end
        chk = ~sum;
        if ($urandom_range(0, 99) < 12) begin
            chk = chk ^ 8'($urandom_range(1, 255));
        end
        send_byte(chk, 1'b0, NO_REPORT);
    endtask

    // Result sink: mostly ready, short stalls, rare long ones, and full-speed stretches.
    always @(posedge aclk) begin
        sink_cycle <= sink_cycle + 16'd1;
        if (sink_stall != 0) begin
            sink_stall <= sink_stall - 1;
            m_tready   <= 1'b0;
        end else begin
            sink_pick = $urandom_range(0, 99);
            if (sink_cycle[8:6] == 3'd0 || sink_pick < 70) begin
                m_tready <= 1'b1;
            end else if (sink_pick < 96) begin
                m_tready   <= 1'b0;
                sink_stall <= $urandom_range(0, 2);
            end else begin
                m_tready   <= 1'b0;
                sink_stall <= $urandom_range(10, 40);
            end
        end
    end

    // Compare each result transfer with the oldest pending report.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result: status %0b code %0d value %h last %0b",
                         $time, m_tuser, m_tdata[3:0], m_tdata[28:4], m_tlast);
                failures++;
            end else begin
                oldest_report = pending_reports.pop_front();
                if (m_tuser !== oldest_report.status) begin
                    $display("%0t: status expected %0b actual %0b",
                             $time, oldest_report.status, m_tuser);
                    failures++;
                end
                if (m_tdata[3:0] !== oldest_report.code) begin
                    $display("%0t: field_code expected %0d actual %0d",
                             $time, oldest_report.code, m_tdata[3:0]);
                    failures++;
                end
                if (m_tdata[28:4] !== oldest_report.value) begin
                    $display("%0t: field_value expected %h actual %h",
                             $time, oldest_report.value, m_tdata[28:4]);
                    failures++;
                end
                if (m_tlast !== oldest_report.last) begin
                    $display("%0t: last_of_packet expected %0b actual %0b",
                             $time, oldest_report.last, m_tlast);
                    failures++;
                end
            end
        end
    end

    initial begin
        parse_phase  = eeg_pp_pkg::PH_SYNC1;
        row_kind     = eeg_pp_pkg::FK_CODE;
        payload_left = '0;
        payload_sum  = '0;
        row_pos      = '0;
        row_acc      = '0;
        staged_mask  = '0;
        for (int s = 0; s < eeg_pp_pkg::NUM_SLOTS; s++) begin
            staged_val[s] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            send_byte(SCRIPT[i].rx, SCRIPT[i].typed, SCRIPT[i].want);
        end
        send_random_packet(1'b1);
        while (items_sent < RANDOM_ITEMS) send_random_packet(1'b0);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        // drain window: catch any extra result after the last expected one
        repeat (100) @(posedge aclk);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
